// ----- sv/sds_pkg.sv -----
package sds_pkg;

    // field and state widths
    localparam int CNT_W    = 4;
    localparam int LEVEL_W  = 17;
    localparam int REG_W    = 16;
    localparam int LFSR_W   = 32;
    localparam int PC_W     = 3;
    localparam int ADDR_W   = 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 17'h1FFFF;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS  = 32'h8020_0003;
    localparam logic [LFSR_W-1:0]  LFSR_SEED  = 32'h0000_ACE1;
    localparam logic [REG_W-1:0]   POLE_RESET = 16'd65000;
    localparam logic [REG_W-1:0]   STEP_RESET = 16'd6554;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_DECAY_POLE = 1'd0;
    localparam logic [ADDR_W-1:0] REG_LEVEL_STEP = 1'd1;

    typedef logic [PC_W-1:0] t_pc;

    // microprogram step addresses
    localparam t_pc PC_WAIT  = 3'd0;
    localparam t_pc PC_FRONT = 3'd1;
    localparam t_pc PC_CHECK = 3'd2;
    localparam t_pc PC_DRAW  = 3'd3;
    localparam t_pc PC_EMIT  = 3'd4;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_FRONT = 3'd2,
        OP_DRAW  = 3'd3,
        OP_EMIT  = 3'd4
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS     = 3'd0,
        COND_ACCEPT     = 3'd1,
        COND_K_LT_CNT   = 3'd2,
        COND_KN_LT_CNT  = 3'd3,
        COND_OUT_FREE   = 3'd4
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_uword;

    // control store
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT:  w = '{OP_LOAD,  COND_ACCEPT,    PC_FRONT, PC_WAIT};
            PC_FRONT: w = '{OP_FRONT, COND_ALWAYS,    PC_CHECK, PC_CHECK};
            PC_CHECK: w = '{OP_NONE,  COND_K_LT_CNT,  PC_DRAW,  PC_EMIT};
            PC_DRAW:  w = '{OP_DRAW,  COND_KN_LT_CNT, PC_DRAW,  PC_EMIT};
            PC_EMIT:  w = '{OP_EMIT,  COND_OUT_FREE,  PC_WAIT,  PC_EMIT};
            default:  w = '{OP_NONE,  COND_ALWAYS,    PC_WAIT,  PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/stochastic_depressing_synapse.sv -----
// an accepted item passes the front and check steps, n draws (n = clamped count, less one for the
//   first spike of a train) and the emit step; a new item is taken only after the last one is emitted
// the draw loop runs one random draw and compare per cycle through a single lfsr and adder
// i_rst_n is synchronous, active low: level and first-spike flag clear, lfsr takes seed 0xACE1,
//   registers take their defaults (pole 65000, step 6554), no result is pending
module stochastic_depressing_synapse #(
    parameter int COUNT_MAX = 15,
    parameter int RAND_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [sds_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  logic [sds_pkg::REG_W-1:0]     i_cfg_wdata,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [3:0] spike_count, [7:4] zero
    input  logic                          i_s_tuser,   // [0] train_start
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata    // [3:0] passed_count, [7:4] zero
);
    import sds_pkg::*;

    localparam logic [CNT_W-1:0] CNT_CLAMP =
        (COUNT_MAX > 15) ? 4'd15 : CNT_W'(COUNT_MAX);
    localparam int DRAW_PAD = LFSR_W - RAND_BITS;

    logic [PC_W-1:0]    r_pc, n_pc;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_passed, n_passed;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_first_seen, n_first_seen;
    logic [LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [REG_W-1:0]   r_decay_pole, n_decay_pole;
    logic [REG_W-1:0]   r_level_step, n_level_step;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_out_data, n_out_data;

    t_uword                      w_uword;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_cond;
    logic [CNT_W-1:0]            w_spikes;
    logic [LFSR_W-1:0]           w_lfsr_next;
    logic [LFSR_W-1:0]           w_draw;
    logic [LEVEL_W+REG_W-1:0]    w_prod;
    logic [LEVEL_W:0]            w_sum;
    logic [LEVEL_W-1:0]          w_raised;
    logic [CNT_W:0]              w_k_next;

    // control word fetch
    assign w_uword    = ucode_rom(r_pc);
    assign o_s_tready = (w_uword.op == OP_LOAD);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_data};

    // datapath helpers
    assign w_spikes    = (i_s_tdata[CNT_W-1:0] > CNT_CLAMP) ? CNT_CLAMP : i_s_tdata[CNT_W-1:0];
    assign w_lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign w_draw      = {{DRAW_PAD{1'b0}}, w_lfsr_next[RAND_BITS-1:0]};
    assign w_prod      = {{REG_W{1'b0}}, r_level} * {{LEVEL_W{1'b0}}, r_decay_pole};
    assign w_sum       = {1'b0, r_level} + {2'b00, r_level_step};
    assign w_raised    = w_sum[LEVEL_W] ? LEVEL_MAX : w_sum[LEVEL_W-1:0];
    assign w_k_next    = {1'b0, r_k} + 5'd1;

    // jump condition
    always_comb begin
        case (w_uword.cond)
            COND_ALWAYS:    w_cond = 1'b1;
            COND_ACCEPT:    w_cond = w_accept;
            COND_K_LT_CNT:  w_cond = (r_k < r_count);
            COND_KN_LT_CNT: w_cond = (w_k_next < {1'b0, r_count});
            COND_OUT_FREE:  w_cond = w_out_free;
            default:        w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_uword.tgt_true : w_uword.tgt_false;
    end

    // datapath driven by the control word
    always_comb begin
        n_count      = r_count;
        n_k          = r_k;
        n_passed     = r_passed;
        n_level      = r_level;
        n_first_seen = r_first_seen;
        n_lfsr       = r_lfsr;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_decay_pole = r_decay_pole;
        n_level_step = r_level_step;

        if (i_cfg_we) begin
            if (i_cfg_addr == REG_DECAY_POLE) begin
                n_decay_pole = i_cfg_wdata;
            end else if (i_cfg_addr == REG_LEVEL_STEP) begin
                n_level_step = i_cfg_wdata;
            end
        end

        case (w_uword.op)
            OP_LOAD: begin
                if (w_accept) begin
                    n_count = w_spikes;
                    if (i_s_tuser) begin
                        n_first_seen = 1'b0;
                    end
                end
            end
            OP_FRONT: begin
                n_k      = '0;
                n_passed = '0;
                if (!r_first_seen) begin
                    // first spike of the train always passes
                    if (r_count != '0) begin
                        n_first_seen = 1'b1;
                        n_level      = {1'b0, r_level_step};
                        n_passed     = 4'd1;
                        n_k          = 4'd1;
                    end
                end else begin
                    // decay by the pole, truncating
                    n_level = w_prod[LEVEL_W+REG_W-1:REG_W];
                end
            end
            OP_DRAW: begin
                n_lfsr = w_lfsr_next;
                n_k    = w_k_next[CNT_W-1:0];
                if (LFSR_W'(r_level) <= w_draw) begin
                    n_level  = w_raised;
                    n_passed = r_passed + 4'd1;
                end
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_passed;
                end
            end
            default: begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_WAIT;
            r_level      <= '0;
            r_first_seen <= 1'b0;
            r_lfsr       <= LFSR_SEED;
            r_decay_pole <= POLE_RESET;
            r_level_step <= STEP_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc         <= n_pc;
            r_level      <= n_level;
            r_first_seen <= n_first_seen;
            r_lfsr       <= n_lfsr;
            r_decay_pole <= n_decay_pole;
            r_level_step <= n_level_step;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_k        <= n_k;
        r_passed   <= n_passed;
        r_out_data <= n_out_data;
    end

`ifndef ASSERT_OFF
    // an accepted item moves on to the front step
    a_accept_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_pc == PC_FRONT))
        else $error("accepted item did not reach front step");

    // draws happen only after the first spike and within the count
    a_draw_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DRAW) |-> (r_first_seen && (r_k < r_count)))
        else $error("draw outside the spike loop");

    // passed spikes never outnumber handled spikes
    a_passed_le_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DRAW || r_pc == PC_EMIT) |-> (r_passed <= r_k))
        else $error("passed count above handled count");

    // lfsr never locks up at zero
    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("lfsr reached zero");
`endif

endmodule
